[hw/rtl/assert_macros.svh]
// Assertion macros shared by the CashAddr payload encoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true on a rising clk edge outside of reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[hw/rtl/cpe_pkg.sv]
// Types, constants and functions shared by the CashAddr payload encoder.
package cpe_pkg;

  localparam int DATA_W      = 8;
  localparam int HLEN_W      = 7;
  localparam int CHAR_W      = 7;
  localparam int SYM_W       = 5;
  localparam int PM_W        = 40;
  localparam int CFG_DATA_W  = 60;
  localparam int CFG_IDX_W   = 1;
  localparam int PLEN_W      = 4;
  localparam int ACC_W       = 12;
  localparam int RG_CNT_W    = 4;
  localparam int CHK_SYMS    = 8;
  localparam int CHK_CNT_W   = 3;
  localparam int MAX_PREFIX_SYMBOLS_DEF = 12;

  localparam logic [PLEN_W-1:0] PREFIX_LEN_RST = 4'd11;
  localparam logic [CFG_DATA_W-1:0] PREFIX_SYMS_RST = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PREFIX_SYMBOLS = 1'b0,
    CFG_PREFIX_LENGTH  = 1'b1
  } cfg_reg_t;

  localparam logic [PM_W-1:0] BCH_GEN [SYM_W] = '{
    40'h98f2bc8e61, 40'h79b76d99e2, 40'hf33e5fb3c4, 40'hae2eabe2a8, 40'h1e4f43e470
  };

  localparam logic [CHAR_W-1:0] ALPHABET [32] = '{
    7'd113, 7'd112, 7'd122, 7'd114, 7'd121, 7'd57,  7'd120, 7'd56,
    7'd103, 7'd102, 7'd50,  7'd116, 7'd118, 7'd100, 7'd119, 7'd48,
    7'd115, 7'd51,  7'd106, 7'd110, 7'd53,  7'd52,  7'd107, 7'd104,
    7'd99,  7'd101, 7'd54,  7'd109, 7'd117, 7'd97,  7'd55,  7'd108
  };

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREFIX,
    S_EMIT,
    S_PAD,
    S_ZERO,
    S_CHECK,
    S_ERR
  } state_t;

  typedef enum logic [1:0] {
    PM_HOLD,
    PM_INIT,
    PM_FEED,
    PM_SHIFT
  } pm_op_t;

  typedef struct packed {
    pm_op_t           op;
    logic [SYM_W-1:0] sym;
  } pm_ctl_t;

  typedef enum logic [2:0] {
    RG_HOLD,
    RG_CLEAR,
    RG_SET,
    RG_LOAD,
    RG_TAKE
  } rg_op_t;

  typedef struct packed {
    rg_op_t            op;
    logic [DATA_W-1:0] data;
  } rg_ctl_t;

  typedef struct packed {
    logic             push;
    logic [SYM_W-1:0] sym;
    logic             last;
    logic             err;
  } out_ctl_t;

  // Returns {valid, size code} for a declared hash length.
  function automatic logic [3:0] size_code(input logic [HLEN_W-1:0] len);
    logic [3:0] res;
    unique case (len)
      7'd20:   res = {1'b1, 3'd0};
      7'd24:   res = {1'b1, 3'd1};
      7'd28:   res = {1'b1, 3'd2};
      7'd32:   res = {1'b1, 3'd3};
      7'd40:   res = {1'b1, 3'd4};
      7'd48:   res = {1'b1, 3'd5};
      7'd56:   res = {1'b1, 3'd6};
      7'd64:   res = {1'b1, 3'd7};
      default: res = 4'b0000;
    endcase
    return res;
  endfunction

endpackage

[hw/rtl/cpe_in_if.sv]
// Input channel: one hash byte word with its address markers.
interface cpe_in_if
  import cpe_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              first_byte;
  logic              last_byte;
  logic              script_hash;
  logic [HLEN_W-1:0] hash_bytes;

  modport source (
    output valid, data_byte, first_byte, last_byte, script_hash, hash_bytes,
    input  ready
  );
  modport sink (
    input  valid, data_byte, first_byte, last_byte, script_hash, hash_bytes,
    output ready
  );
endinterface

[hw/rtl/cpe_out_if.sv]
// Result channel: one base32 character word with its markers.
interface cpe_out_if
  import cpe_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last_char;
  logic              error;

  modport source (
    output valid, character, last_char, error,
    input  ready
  );
  modport sink (
    input  valid, character, last_char, error,
    output ready
  );
endinterface

[hw/rtl/cpe_polymod.sv]
// BCH polymod register that takes one 5-bit symbol per cycle while its control selects a feed.
module cpe_polymod
  import cpe_pkg::*;
  (
  input  logic             clk,
  input  logic             rst_n,
  input  pm_ctl_t          ctl,
  output logic [SYM_W-1:0] top_sym
);

  logic [PM_W-1:0] st_r;
  logic [PM_W-1:0] st_nxt;
  logic [PM_W-1:0] fed;

  always_comb begin
    fed = {st_r[PM_W-SYM_W-1:0], {SYM_W{1'b0}}} ^ {{(PM_W-SYM_W){1'b0}}, ctl.sym};
    for (int j = 0; j < SYM_W; j++) begin
      if (st_r[PM_W-SYM_W+j]) begin
        fed = fed ^ BCH_GEN[j];
      end
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (ctl.op)
      PM_HOLD:  st_nxt = st_r;
      PM_INIT:  st_nxt = {{(PM_W-1){1'b0}}, 1'b1};
      PM_FEED:  st_nxt = fed;
      PM_SHIFT: st_nxt = {st_r[PM_W-SYM_W-1:0], {SYM_W{1'b0}}};
      default:  st_nxt = st_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= {{(PM_W-1){1'b0}}, 1'b1};
    end else begin
      st_r <= st_nxt;
    end
  end

  assign top_sym = st_r[PM_W-1 -: SYM_W];

endmodule

[hw/rtl/cpe_regroup.sv]
// Bit shift register that regroups bytes into 5-bit symbols, MSB first.
module cpe_regroup
  import cpe_pkg::*;
  (
  input  logic                clk,
  input  logic                rst_n,
  input  rg_ctl_t             ctl,
  output logic [SYM_W-1:0]    sym,
  output logic [RG_CNT_W-1:0] cnt
);

  logic [ACC_W-1:0]    acc_r;
  logic [ACC_W-1:0]    acc_nxt;
  logic [RG_CNT_W-1:0] cnt_r;
  logic [RG_CNT_W-1:0] cnt_nxt;
  logic [ACC_W-1:0]    aligned;

  assign aligned = {ctl.data, {(ACC_W-DATA_W){1'b0}}};

  always_comb begin
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    unique case (ctl.op)
      RG_HOLD: begin
        acc_nxt = acc_r;
      end
      RG_CLEAR: begin
        acc_nxt = '0;
        cnt_nxt = '0;
      end
      RG_SET: begin
        acc_nxt = aligned;
        cnt_nxt = RG_CNT_W'(DATA_W);
      end
      RG_LOAD: begin
        acc_nxt = acc_r | (aligned >> cnt_r);
        cnt_nxt = cnt_r + RG_CNT_W'(DATA_W);
      end
      RG_TAKE: begin
        acc_nxt = acc_r << SYM_W;
        cnt_nxt = (cnt_r >= RG_CNT_W'(SYM_W)) ? cnt_r - RG_CNT_W'(SYM_W) : '0;
      end
      default: begin
        acc_nxt = acc_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      cnt_r <= '0;
    end else begin
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign sym = acc_r[ACC_W-1 -: SYM_W];
  assign cnt = cnt_r;

endmodule

[hw/rtl/cpe_out_stage.sv]
// Output register that maps symbols to base32 characters.
module cpe_out_stage
  import cpe_pkg::*;
  (
  input  logic     clk,
  input  logic     rst_n,
  input  out_ctl_t ctl,
  output logic     slot_free,
  cpe_out_if.source out_chan
);

  logic              valid_r;
  logic              valid_nxt;
  logic [CHAR_W-1:0] char_r;
  logic [CHAR_W-1:0] char_nxt;
  logic              last_r;
  logic              err_r;

  assign slot_free = !valid_r || out_chan.ready;

  always_comb begin
    if (ctl.push) begin
      valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
    char_nxt = ctl.err ? '0 : ALPHABET[ctl.sym];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      char_r <= char_nxt;
      last_r <= ctl.last;
      err_r  <= ctl.err;
    end
  end

  assign out_chan.valid     = valid_r;
  assign out_chan.character = char_r;
  assign out_chan.last_char = last_r;
  assign out_chan.error     = err_r;

  `include "assert_macros.svh"

  `ASSERT_NEVER(a_no_overwrite, ctl.push && valid_r && !out_chan.ready, "held word overwritten")
  `ASSERT_CLK(a_err_is_last, (valid_r && err_r) |-> last_r, "error word without last mark")

endmodule

[hw/rtl/cashaddr_payload_encoder.sv]
// Top level of the CashAddr payload encoder: control sequencer and configuration.
//
// The block takes one hash byte per word and sends the base32 payload and checksum
// characters, one per word, through a single output register. A middle byte is
// accepted, gives one or two symbols and then returns the block to idle. The first
// byte adds prefix_length plus one polymod feeds for the prefix and separator, with
// prefix_length saturated, then the version symbol and a reload of the byte. The last
// byte adds a pad symbol where bits remain, eight polymod feeds and eight checksum
// characters. The polymod absorbs one 5-bit symbol per cycle when fed, and the
// output register holds one character; a stalled output stalls symbol production.
// Configuration is taken at any time.
module cashaddr_payload_encoder
  import cpe_pkg::*;
  #(
  parameter int MAX_PREFIX_SYMBOLS = MAX_PREFIX_SYMBOLS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  cpe_in_if.sink                in_chan,
  cpe_out_if.source             out_chan
);

  localparam int PFX_W  = SYM_W * MAX_PREFIX_SYMBOLS;
  localparam int PCNT_W = $clog2(MAX_PREFIX_SYMBOLS + 1);

  state_t state_r;
  state_t state_nxt;

  logic [PFX_W-1:0]     prefix_r;
  logic [PLEN_W-1:0]    plen_cfg_r;
  logic [PFX_W-1:0]     pfx_sh_r;
  logic [PFX_W-1:0]     pfx_sh_nxt;
  logic [PCNT_W-1:0]    pfx_cnt_r;
  logic [PCNT_W-1:0]    pfx_cnt_nxt;
  logic [PCNT_W-1:0]    plen_sat;
  logic                 skip_r;
  logic                 skip_nxt;
  logic [HLEN_W-1:0]    seen_r;
  logic [HLEN_W-1:0]    seen_nxt;
  logic [HLEN_W-1:0]    decl_r;
  logic [HLEN_W-1:0]    decl_nxt;
  logic [DATA_W-1:0]    hold_r;
  logic [DATA_W-1:0]    hold_nxt;
  logic                 byte_pend_r;
  logic                 byte_pend_nxt;
  logic                 last_r;
  logic                 last_nxt;
  logic [CHK_CNT_W-1:0] chk_cnt_r;
  logic [CHK_CNT_W-1:0] chk_cnt_nxt;

  logic                 in_acc;
  logic [3:0]           sc;
  logic                 len_ok;
  logic [HLEN_W-1:0]    cnt_next;
  logic [HLEN_W-1:0]    decl_cmp;
  logic                 cnt_err;
  logic                 is_err;
  logic                 is_skip;
  logic [DATA_W-1:0]    version;

  pm_ctl_t              pm_ctl;
  rg_ctl_t              rg_ctl;
  out_ctl_t             oc;
  logic [SYM_W-1:0]     pm_top;
  logic [SYM_W-1:0]     rg_sym;
  logic [RG_CNT_W-1:0]  rg_cnt;
  logic                 sym_rdy;
  logic                 slot_free;

  cpe_polymod u_polymod (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (pm_ctl),
    .top_sym (pm_top)
  );

  cpe_regroup u_regroup (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (rg_ctl),
    .sym   (rg_sym),
    .cnt   (rg_cnt)
  );

  cpe_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (oc),
    .slot_free (slot_free),
    .out_chan  (out_chan)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r   <= PREFIX_SYMS_RST[CFG_DATA_W-1 -: PFX_W];
      plen_cfg_r <= PREFIX_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PREFIX_SYMBOLS: prefix_r   <= cfg_wdata[CFG_DATA_W-1 -: PFX_W];
        CFG_PREFIX_LENGTH:  plen_cfg_r <= cfg_wdata[PLEN_W-1:0];
        default:            prefix_r   <= prefix_r;
      endcase
    end
  end

  assign plen_sat = (plen_cfg_r > PLEN_W'(MAX_PREFIX_SYMBOLS)) ?
                    PCNT_W'(MAX_PREFIX_SYMBOLS) : PCNT_W'(plen_cfg_r);

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;

  assign sc       = size_code(in_chan.hash_bytes);
  assign len_ok   = sc[3];
  assign version  = {{(DATA_W-4){1'b0}}, in_chan.script_hash, sc[2:0]};
  assign cnt_next = in_chan.first_byte ? HLEN_W'(1) : seen_r + HLEN_W'(1);
  assign decl_cmp = in_chan.first_byte ? in_chan.hash_bytes : decl_r;
  assign cnt_err  = in_chan.last_byte ? (cnt_next != decl_cmp) : (cnt_next >= decl_cmp);
  assign is_skip  = !in_chan.first_byte && skip_r;
  assign is_err   = in_chan.first_byte ? (!len_ok || cnt_err) : (!skip_r && cnt_err);
  assign sym_rdy  = (rg_cnt >= RG_CNT_W'(SYM_W));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (is_err) begin
            state_nxt = S_ERR;
          end else if (!is_skip) begin
            state_nxt = in_chan.first_byte ? S_PREFIX : S_EMIT;
          end
        end
      end
      S_PREFIX: begin
        if (pfx_cnt_r == '0) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!sym_rdy && !byte_pend_r) begin
          if (!last_r) begin
            state_nxt = S_IDLE;
          end else if (rg_cnt != '0) begin
            state_nxt = S_PAD;
          end else begin
            state_nxt = S_ZERO;
          end
        end
      end
      S_PAD: begin
        if (slot_free) begin
          state_nxt = S_ZERO;
        end
      end
      S_ZERO: begin
        if (chk_cnt_r == '1) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (slot_free && chk_cnt_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_ERR: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    pm_ctl.op     = PM_HOLD;
    pm_ctl.sym    = '0;
    rg_ctl.op     = RG_HOLD;
    rg_ctl.data   = '0;
    oc.push       = 1'b0;
    oc.sym        = '0;
    oc.last       = 1'b0;
    oc.err        = 1'b0;
    skip_nxt      = skip_r;
    seen_nxt      = seen_r;
    decl_nxt      = decl_r;
    hold_nxt      = hold_r;
    byte_pend_nxt = byte_pend_r;
    last_nxt      = last_r;
    chk_cnt_nxt   = chk_cnt_r;
    pfx_sh_nxt    = pfx_sh_r;
    pfx_cnt_nxt   = pfx_cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && !is_skip) begin
          if (is_err) begin
            skip_nxt = 1'b1;
            seen_nxt = '0;
            decl_nxt = '0;
          end else if (in_chan.first_byte) begin
            skip_nxt      = 1'b0;
            decl_nxt      = in_chan.hash_bytes;
            seen_nxt      = cnt_next;
            pm_ctl.op     = PM_INIT;
            rg_ctl.op     = RG_SET;
            rg_ctl.data   = version;
            hold_nxt      = in_chan.data_byte;
            byte_pend_nxt = 1'b1;
            last_nxt      = in_chan.last_byte;
            pfx_sh_nxt    = prefix_r;
            pfx_cnt_nxt   = plen_sat;
          end else begin
            seen_nxt      = cnt_next;
            rg_ctl.op     = RG_LOAD;
            rg_ctl.data   = in_chan.data_byte;
            byte_pend_nxt = 1'b0;
            last_nxt      = in_chan.last_byte;
          end
        end
      end
      S_PREFIX: begin
        pm_ctl.op = PM_FEED;
        if (pfx_cnt_r != '0) begin
          pm_ctl.sym  = pfx_sh_r[PFX_W-1 -: SYM_W];
          pfx_sh_nxt  = pfx_sh_r << SYM_W;
          pfx_cnt_nxt = pfx_cnt_r - PCNT_W'(1);
        end
      end
      S_EMIT: begin
        if (sym_rdy) begin
          if (slot_free) begin
            oc.push    = 1'b1;
            oc.sym     = rg_sym;
            pm_ctl.op  = PM_FEED;
            pm_ctl.sym = rg_sym;
            rg_ctl.op  = RG_TAKE;
          end
        end else if (byte_pend_r) begin
          rg_ctl.op     = RG_LOAD;
          rg_ctl.data   = hold_r;
          byte_pend_nxt = 1'b0;
        end else begin
          chk_cnt_nxt = '0;
        end
      end
      S_PAD: begin
        if (slot_free) begin
          oc.push    = 1'b1;
          oc.sym     = rg_sym;
          pm_ctl.op  = PM_FEED;
          pm_ctl.sym = rg_sym;
          rg_ctl.op  = RG_TAKE;
        end
      end
      S_ZERO: begin
        // Feeding 1 instead of 0 on the final round folds in the closing XOR with 1.
        pm_ctl.op   = PM_FEED;
        pm_ctl.sym  = (chk_cnt_r == '1) ? SYM_W'(1) : '0;
        chk_cnt_nxt = chk_cnt_r + CHK_CNT_W'(1);
      end
      S_CHECK: begin
        if (slot_free) begin
          oc.push     = 1'b1;
          oc.sym      = pm_top;
          oc.last     = (chk_cnt_r == '1);
          pm_ctl.op   = PM_SHIFT;
          chk_cnt_nxt = chk_cnt_r + CHK_CNT_W'(1);
          if (chk_cnt_r == '1) begin
            seen_nxt  = '0;
            decl_nxt  = '0;
            rg_ctl.op = RG_CLEAR;
          end
        end
      end
      S_ERR: begin
        if (slot_free) begin
          oc.push = 1'b1;
          oc.last = 1'b1;
          oc.err  = 1'b1;
        end
      end
      default: begin
        pm_ctl.op = PM_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      skip_r      <= 1'b0;
      seen_r      <= '0;
      decl_r      <= '0;
      byte_pend_r <= 1'b0;
      last_r      <= 1'b0;
      chk_cnt_r   <= '0;
      pfx_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      skip_r      <= skip_nxt;
      seen_r      <= seen_nxt;
      decl_r      <= decl_nxt;
      byte_pend_r <= byte_pend_nxt;
      last_r      <= last_nxt;
      chk_cnt_r   <= chk_cnt_nxt;
      pfx_cnt_r   <= pfx_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r   <= hold_nxt;
    pfx_sh_r <= pfx_sh_nxt;
  end

  `include "assert_macros.svh"

  `ASSERT_CLK(a_bad_len_err,
              (in_acc && in_chan.first_byte && !len_ok) |=> (state_r == S_ERR),
              "invalid length did not raise an error")
  `ASSERT_CLK(a_skip_silent,
              (in_acc && skip_r && !in_chan.first_byte) |=> (state_r == S_IDLE),
              "skipped byte started work")
  `ASSERT_CLK(a_bits_drained,
              (state_r == S_ZERO || state_r == S_CHECK) |-> (rg_cnt == '0),
              "payload bits left at checksum time")

endmodule
